### src/transfer_data_block_segmenter_core_assert.svh
// Assertion macros for the block segmenter.
// Each macro takes a label, a clock, an active-low reset and a property body.
`ifndef TRANSFER_DATA_BLOCK_SEGMENTER_CORE_ASSERT_SVH
`define TRANSFER_DATA_BLOCK_SEGMENTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Check that prop holds at every clock edge outside reset.
`define TDBS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("tdbs assertion failed");

// Check that expr never becomes true outside reset.
`define TDBS_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("tdbs forbidden condition seen");

`else

`define TDBS_ASSERT(lbl, clk, rstn, prop)
`define TDBS_ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

### src/tdbs_pkg.sv
package tdbs_pkg;

  // Field and register widths
  localparam int BYTE_W       = 8;
  localparam int BLOCK_LEN_W  = 13;
  localparam int IMAGE_LEN_W  = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_LENGTH = 2'd1;

  // Register reset values
  localparam logic [BLOCK_LEN_W-1:0] BLOCK_LENGTH_RST = 13'd1026;
  localparam logic [IMAGE_LEN_W-1:0] IMAGE_LENGTH_RST = 32'd0;

  // Block framing
  localparam logic [BYTE_W-1:0] SERVICE_ID       = 8'h36;
  localparam logic [BYTE_W-1:0] SEQ_START        = 8'd1;
  localparam int                MIN_BLOCK_LENGTH = 3;
  localparam int                HEADER_BYTES     = 2;

  // Which byte of the pending item the output stage presents
  typedef enum logic [1:0] {
    BEAT_SID,
    BEAT_SEQ,
    BEAT_DATA
  } beat_e;

endpackage

### src/transfer_data_block_segmenter_core.sv
// Transfer-data block segmenter.
//
// Input channel (in_valid_i / in_stall_o / data_byte_i): one image byte per
// word, in address order. Output channel (out_valid_o / out_stall_i) carries
// the block stream: out_byte_o plus is_header_o, last_of_block_o and
// last_of_image_o. A word moves when valid is high and stall is low.
// Configuration port (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_wdata_i):
// index 0 is block_length, index 1 is image_length; other indexes are dropped.
// Write it only while the block is idle.
//
// The first stream byte for an input word appears in the cycle after the
// word is taken. A byte in the middle of a block goes out on its own; a
// byte that opens a block follows the service byte and the sequence
// counter, which go out of the same single output stage ahead of it.
// The next input word is taken in the cycle the data byte of the current one
// leaves, so the stream runs gap free.
//
// Reset clears all counters (sequence counter back to 1) and loads the
// register defaults. When the receiver stalls, the output stage holds its
// word and in_stall_o rises as soon as no free slot remains.
`include "transfer_data_block_segmenter_core_assert.svh"

module transfer_data_block_segmenter_core #(
  parameter int MAX_BLOCK_LENGTH = 4098
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tdbs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tdbs_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // image byte input
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [tdbs_pkg::BYTE_W-1:0]       data_byte_i,
  // block stream output
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [tdbs_pkg::BYTE_W-1:0]       out_byte_o,
  output logic                              is_header_o,
  output logic                              last_of_block_o,
  output logic                              last_of_image_o
);

  // Payload capacity runs up to MAX_BLOCK_LENGTH-2; the payload count stays
  // below it.
  localparam int CW  = $clog2(MAX_BLOCK_LENGTH - 1);
  localparam int PCW = (MAX_BLOCK_LENGTH > 3) ? $clog2(MAX_BLOCK_LENGTH - 2) : 1;
  localparam int MLW = $clog2(MAX_BLOCK_LENGTH + 1);
  localparam int LW  = (MLW > tdbs_pkg::BLOCK_LEN_W) ? MLW : tdbs_pkg::BLOCK_LEN_W;
  localparam int IW  = tdbs_pkg::IMAGE_LEN_W;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [tdbs_pkg::BLOCK_LEN_W-1:0] block_length_q;
  logic [IW-1:0]                    image_length_q;
  logic                             cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_length_q <= tdbs_pkg::BLOCK_LENGTH_RST;
      image_length_q <= tdbs_pkg::IMAGE_LENGTH_RST;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        tdbs_pkg::REG_BLOCK_LENGTH: begin
          block_length_q <= cfg_wdata_i[tdbs_pkg::BLOCK_LEN_W-1:0];
        end
        tdbs_pkg::REG_IMAGE_LENGTH: begin
          image_length_q <= cfg_wdata_i[IW-1:0];
        end
        default: begin
          // unknown index: drop the write
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Segmentation state
  // ---------------------------------------------------------------------
  logic [PCW-1:0]                pcount_q, pcount_d;
  logic [tdbs_pkg::BYTE_W-1:0]   seq_num_q, seq_num_d;
  logic [IW-1:0]                 bytes_sent_q, bytes_sent_d;

  // Output stage
  logic                          out_vld_q, out_vld_d;
  tdbs_pkg::beat_e               beat_q, beat_d;
  logic [tdbs_pkg::BYTE_W-1:0]   data_q;
  logic [tdbs_pkg::BYTE_W-1:0]   seq_out_q;
  logic                          lob_q, loi_q;

  logic                          in_acc;
  logic                          out_take;
  logic                          last_beat;

  // Clamp the block length and derive the payload capacity.
  logic [LW-1:0]  blen_ext;
  logic [LW-1:0]  blen_eff;
  logic [CW:0]    cap;
  logic [CW:0]    pcount_inc;
  logic [IW:0]    sent_after;
  logic           end_image;
  logic           end_block;
  logic           block_start;

  always_comb begin
    blen_ext = LW'(block_length_q);
    if (blen_ext < LW'(tdbs_pkg::MIN_BLOCK_LENGTH)) begin
      blen_eff = LW'(tdbs_pkg::MIN_BLOCK_LENGTH);
    end else if (blen_ext > LW'(MAX_BLOCK_LENGTH)) begin
      blen_eff = LW'(MAX_BLOCK_LENGTH);
    end else begin
      blen_eff = blen_ext;
    end
    cap = (CW+1)'(blen_eff - LW'(tdbs_pkg::HEADER_BYTES));
  end

  // A zero image length means 2^32 bytes: the image then ends on the byte
  // that brings the count to all ones plus one.
  always_comb begin
    sent_after  = (IW+1)'(bytes_sent_q) + (IW+1)'(1);
    pcount_inc  = (CW+1)'(pcount_q) + (CW+1)'(1);
    if (image_length_q == '0) begin
      end_image = (bytes_sent_q == '1);
    end else begin
      end_image = (sent_after >= (IW+1)'(image_length_q));
    end
    end_block   = end_image || (pcount_inc >= cap);
    block_start = (pcount_q == '0);
  end

  // ---------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------
  assign last_beat  = (beat_q == tdbs_pkg::BEAT_DATA);
  assign out_take   = out_vld_q && !out_stall_i;
  // Take a new word when the stage is empty or its data byte leaves now.
  assign in_stall_o = out_vld_q && !(last_beat && !out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Advance the counters on every accepted word.
  always_comb begin
    pcount_d     = pcount_q;
    seq_num_d    = seq_num_q;
    bytes_sent_d = bytes_sent_q;
    if (in_acc) begin
      if (end_image) begin
        pcount_d     = '0;
        seq_num_d    = tdbs_pkg::SEQ_START;
        bytes_sent_d = '0;
      end else begin
        bytes_sent_d = sent_after[IW-1:0];
        if (end_block) begin
          pcount_d  = '0;
          seq_num_d = seq_num_q + tdbs_pkg::BYTE_W'(1);
        end else begin
          pcount_d  = PCW'(pcount_inc);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcount_q     <= '0;
      seq_num_q    <= tdbs_pkg::SEQ_START;
      bytes_sent_q <= '0;
    end else begin
      pcount_q     <= pcount_d;
      seq_num_q    <= seq_num_d;
      bytes_sent_q <= bytes_sent_d;
    end
  end

  // ---------------------------------------------------------------------
  // Output stage: beat sequencing
  // ---------------------------------------------------------------------
  always_comb begin
    out_vld_d = out_vld_q;
    beat_d    = beat_q;
    if (in_acc) begin
      out_vld_d = 1'b1;
      beat_d    = block_start ? tdbs_pkg::BEAT_SID : tdbs_pkg::BEAT_DATA;
    end else if (out_take) begin
      case (beat_q)
        tdbs_pkg::BEAT_SID:  beat_d = tdbs_pkg::BEAT_SEQ;
        tdbs_pkg::BEAT_SEQ:  beat_d = tdbs_pkg::BEAT_DATA;
        tdbs_pkg::BEAT_DATA: out_vld_d = 1'b0;
        default:             beat_d = tdbs_pkg::BEAT_DATA;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      beat_q    <= tdbs_pkg::BEAT_DATA;
    end else begin
      out_vld_q <= out_vld_d;
      beat_q    <= beat_d;
    end
  end

  // Payload of the pending word; loaded only on accept.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      data_q    <= data_byte_i;
      seq_out_q <= seq_num_q;
      lob_q     <= end_block;
      loi_q     <= end_image;
    end
  end

  // Output decode
  always_comb begin
    out_valid_o     = out_vld_q;
    out_byte_o      = data_q;
    is_header_o     = 1'b0;
    last_of_block_o = 1'b0;
    last_of_image_o = 1'b0;
    case (beat_q)
      tdbs_pkg::BEAT_SID: begin
        out_byte_o  = tdbs_pkg::SERVICE_ID;
        is_header_o = 1'b1;
      end
      tdbs_pkg::BEAT_SEQ: begin
        out_byte_o  = seq_out_q;
        is_header_o = 1'b1;
      end
      tdbs_pkg::BEAT_DATA: begin
        out_byte_o      = data_q;
        last_of_block_o = lob_q;
        last_of_image_o = loi_q;
      end
      default: begin
        out_byte_o = data_q;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // A word that opens a block shows the service byte first.
  `TDBS_ASSERT(a_hdr_first, clk_i, rst_ni,
    in_acc && block_start |=> out_valid_o && is_header_o && out_byte_o == tdbs_pkg::SERVICE_ID)
  // At the start of an image every counter sits at its start value.
  `TDBS_ASSERT(a_image_start, clk_i, rst_ni,
    bytes_sent_q == '0 |-> seq_num_q == tdbs_pkg::SEQ_START && pcount_q == '0)
  // The end of the image always closes a block.
  `TDBS_ASSERT_NEVER(a_loi_lob, clk_i, rst_ni,
    out_valid_o && last_of_image_o && !last_of_block_o)

endmodule
